// File: rtl/line_substring_filter_defines.svh
// Assertion macros for the line substring filter.
`ifndef LINE_SUBSTRING_FILTER_DEFINES_SVH
`define LINE_SUBSTRING_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define LSF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("line_substring_filter: same-cycle check failed");
`define LSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("line_substring_filter: next-cycle check failed");
`else
`define LSF_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define LSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/lsf_pkg.sv
`default_nettype none

package lsf_pkg;

	localparam int PATTERN_BYTES = 30;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LENGTH_W = 9;

	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_END = 8'hFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_0_7 = 3'd1,
		REG_PATTERN_8_15 = 3'd2,
		REG_PATTERN_16_23 = 3'd3,
		REG_PATTERN_24_29 = 3'd4
	} cfg_reg_t;

	typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

// File: rtl/line_substring_filter.sv
// A result word is registered when a newline or line-filling byte leaves the input register.
// Throughput: one text byte per cycle; the input stalls only while a finished
// line result waits in the output register and the output is not ready.
// Reset: arst_n clears the pattern registers, cnt_q, found_q and all valid flags at once;
// no clearing pass is needed.
`default_nettype none

`include "line_substring_filter_defines.svh"

module line_substring_filter #(
	parameter int MAX_PATTERN = 30,
	parameter int MAX_LINE = 256
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,

	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] text_byte,

	output logic out_valid,
	input wire logic out_ready,
	output logic line_matched,
	output logic [lsf_pkg::LENGTH_W-1:0] line_length
);

	localparam int CNT_W = $clog2(MAX_LINE + 1);
	localparam int PLEN_W = 6;
	localparam int CMP_W = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;
	localparam int LEN_EXT_W = (CNT_W > lsf_pkg::LENGTH_W) ? CNT_W : lsf_pkg::LENGTH_W;
	localparam int LEN_MAX = (1 << lsf_pkg::LENGTH_W) - 1;

	// Configuration registers.
	logic [4:0] pat_len_q;
	lsf_pkg::byte_t pat_q [lsf_pkg::PATTERN_BYTES];

	// Input register.
	logic valid_s1;
	lsf_pkg::byte_t byte_s1;

	// Line state.
	lsf_pkg::byte_t win_q [MAX_PATTERN];
	logic [CNT_W-1:0] cnt_q;
	logic found_q;

	// Output register.
	logic out_valid_q;
	logic out_matched_q;
	logic [lsf_pkg::LENGTH_W-1:0] out_len_q;

	logic is_end;
	logic is_nl;
	logic is_text;
	logic [PLEN_W-1:0] plen;
	lsf_pkg::byte_t win_next [MAX_PATTERN];
	lsf_pkg::byte_t pat_ext [MAX_PATTERN];
	lsf_pkg::byte_t sel_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pos_ok;
	logic [CNT_W-1:0] cnt_inc;
	logic enough_bytes;
	logic hit_now;
	logic found_next;
	logic line_full;
	logic emit;
	logic stall;
	logic fire_s1;
	logic res_matched;
	logic [CNT_W-1:0] res_cnt;
	logic [LEN_EXT_W-1:0] res_cnt_ext;
	logic [lsf_pkg::LENGTH_W-1:0] res_len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			for (int i = 0; i < lsf_pkg::PATTERN_BYTES; i++) begin
				pat_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lsf_pkg::REG_PATTERN_LENGTH: begin
					pat_len_q <= cfg_data[4:0];
				end
				lsf_pkg::REG_PATTERN_0_7: begin
					for (int i = 0; i < 8; i++) pat_q[i] <= cfg_data[8*i +: 8];
				end
				lsf_pkg::REG_PATTERN_8_15: begin
					for (int i = 0; i < 8; i++) pat_q[8 + i] <= cfg_data[8*i +: 8];
				end
				lsf_pkg::REG_PATTERN_16_23: begin
					for (int i = 0; i < 8; i++) pat_q[16 + i] <= cfg_data[8*i +: 8];
				end
				lsf_pkg::REG_PATTERN_24_29: begin
					for (int i = 0; i < 6; i++) pat_q[24 + i] <= cfg_data[8*i +: 8];
				end
				default: begin
				end
			endcase
		end
	end

	// Classify the registered byte. Carriage returns are dropped.
	always_comb begin
		is_end = 1'b0;
		is_nl = 1'b0;
		is_text = 1'b0;
		unique case (byte_s1) inside
			lsf_pkg::BYTE_NUL, lsf_pkg::BYTE_END: is_end = 1'b1;
			lsf_pkg::BYTE_NEWLINE: is_nl = 1'b1;
			lsf_pkg::BYTE_CR: begin
			end
			default: is_text = 1'b1;
		endcase
	end

	assign plen = (PLEN_W'(pat_len_q) > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
		: PLEN_W'(pat_len_q);

	// The newest byte sits at window position zero. Pattern byte j lines up with
	// window position plen-1-j.
	always_comb begin
		win_next[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_next[k] = win_q[k-1];
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (j < lsf_pkg::PATTERN_BYTES) begin
				pat_ext[j] = pat_q[j];
			end else begin
				pat_ext[j] = '0;
			end
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			sel_byte[j] = '0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (plen == PLEN_W'(i + j + 1)) sel_byte[j] = win_next[i];
			end
			pos_ok[j] = (PLEN_W'(j) >= plen) || (sel_byte[j] == pat_ext[j]);
		end
	end

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign enough_bytes = CMP_W'(cnt_inc) >= CMP_W'(plen);
	assign hit_now = enough_bytes && (&pos_ok);
	assign found_next = found_q || hit_now;
	assign line_full = cnt_inc == CNT_W'(MAX_LINE);

	assign emit = is_nl || (is_text && line_full);
	assign stall = valid_s1 && emit && out_valid_q && !out_ready;
	assign in_ready = !stall;
	assign fire_s1 = valid_s1 && !stall;

	assign res_matched = (is_nl ? found_q : found_next) || (plen == '0);
	assign res_cnt = is_nl ? cnt_q : cnt_inc;
	assign res_cnt_ext = LEN_EXT_W'(res_cnt);
	assign res_len = (res_cnt_ext > LEN_EXT_W'(LEN_MAX)) ? lsf_pkg::LENGTH_W'(LEN_MAX)
		: res_cnt_ext[lsf_pkg::LENGTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			found_q <= 1'b0;
		end else if (fire_s1) begin
			if (is_end || emit) begin
				cnt_q <= '0;
				found_q <= 1'b0;
			end else if (is_text) begin
				cnt_q <= cnt_inc;
				found_q <= found_next;
			end
		end
	end

	// Window bytes older than the line start are masked by the byte count.
	always_ff @(posedge clk) begin
		if (fire_s1 && is_text) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= win_next[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_matched_q <= res_matched;
			out_len_q <= res_len;
		end
	end

	assign out_valid = out_valid_q;
	assign line_matched = out_matched_q;
	assign line_length = out_len_q;

	`LSF_ASSERT_NOW(a_cnt_below_max, clk, arst_n, 1'b1, cnt_q < CNT_W'(MAX_LINE))
	`LSF_ASSERT_NEXT(a_emit_loads_output, clk, arst_n, fire_s1 && emit, out_valid_q)
	`LSF_ASSERT_NEXT(a_end_clears_line, clk, arst_n, fire_s1 && is_end, cnt_q == '0 && !found_q)
	`LSF_ASSERT_NEXT(a_empty_pattern_hits, clk, arst_n, fire_s1 && emit && plen == '0, line_matched)

endmodule

`default_nettype wire
